// File: hw/rtl/wbps_pkg.sv
package wbps_pkg;

  localparam int unsigned MaxPatternLen = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned PatternW      = 128;
  localparam int unsigned CareW         = 16;
  localparam int unsigned LenW          = 5;
  localparam int unsigned CountW        = 32;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned CfgIdxW       = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLow  = 3'd0,
    RegPatternHigh = 3'd1,
    RegCareMask    = 3'd2,
    RegPatternLen  = 3'd3,
    RegSkipCount   = 3'd4
  } cfg_reg_e;

  // Live configuration; len is already clamped to the supported range
  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic [CareW-1:0]    care;
    logic [LenW-1:0]     len;
    logic [CountW-1:0]   skip;
  } cfg_t;

  // One accepted request as seen by the match tracker
  typedef struct packed {
    logic accept;
    logic last;
    logic match;
  } step_t;

endpackage

// File: hw/rtl/wbps_cfg_regs.sv
module wbps_cfg_regs #(
  parameter int unsigned MAX_PATTERN_LEN = wbps_pkg::MaxPatternLen
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output wbps_pkg::cfg_t                 cfg_o
);
  import wbps_pkg::*;

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q;
  logic [CareW-1:0]    care_q;
  logic [LenW-1:0]     len_q;
  logic [CountW-1:0]   skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      len_q    <= LenW'(1);
      skip_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPatternLow:  pat_lo_q <= cfg_wdata_i;
        RegPatternHigh: pat_hi_q <= cfg_wdata_i;
        RegCareMask:    care_q   <= cfg_wdata_i[CareW-1:0];
        RegPatternLen:  len_q    <= cfg_wdata_i[LenW-1:0];
        RegSkipCount:   skip_q   <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversized lengths clamp to the window depth
  always_comb begin
    cfg_o.pattern = {pat_hi_q, pat_lo_q};
    cfg_o.care    = care_q;
    cfg_o.skip    = skip_q;
    if (len_q == '0) begin
      cfg_o.len = LenW'(1);
    end else if (len_q > LenW'(MAX_PATTERN_LEN)) begin
      cfg_o.len = LenW'(MAX_PATTERN_LEN);
    end else begin
      cfg_o.len = len_q;
    end
  end

endmodule

// File: hw/rtl/wbps_window.sv
module wbps_window #(
  parameter int unsigned MAX_PATTERN_LEN = wbps_pkg::MaxPatternLen
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         last_i,
  input  logic [wbps_pkg::ByteW-1:0]   byte_i,
  input  wbps_pkg::cfg_t               cfg_i,
  output logic                         match_o
);
  import wbps_pkg::*;

  logic [ByteW-1:0] win_q [MAX_PATTERN_LEN];
  logic [ByteW-1:0] win_d [MAX_PATTERN_LEN];

  // Window after taking the new byte; entry 0 is the newest
  always_comb begin
    win_d[0] = byte_i;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // Pattern byte j lines up with window entry len-1-j
  always_comb begin
    logic [ByteW-1:0] sel;
    match_o = 1'b1;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      sel = '0;
      for (int s = 0; s < MAX_PATTERN_LEN; s++) begin
        if (LenW'(s + j + 1) == cfg_i.len) begin
          sel = win_d[s];
        end
      end
      if (cfg_i.care[j] && (LenW'(j) < cfg_i.len) &&
          (sel != cfg_i.pattern[j*ByteW +: ByteW])) begin
        match_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN_LEN; k++) win_q[k] <= '0;
    end else if (accept_i) begin
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        win_q[k] <= last_i ? '0 : win_d[k];
      end
    end
  end

endmodule

// File: hw/rtl/wbps_tracker.sv
module wbps_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wbps_pkg::step_t               step_i,
  input  wbps_pkg::cfg_t                cfg_i,
  input  logic                          out_ready_i,
  output logic                          out_free_o,
  output logic                          out_valid_o,
  output logic                          found_o,
  output logic [wbps_pkg::CountW-1:0]   offset_o
);
  import wbps_pkg::*;

  logic [CountW-1:0] bytes_q, bytes_d, bytes_inc;
  logic [CountW-1:0] matches_q, matches_d;
  logic              reported_q, reported_d;
  logic              valid_q, valid_d;
  logic              found_q, found_d;
  logic [CountW-1:0] offset_q, offset_d;
  logic              hit, report_now, emit;

  assign out_free_o = !valid_q || out_ready_i;

  assign bytes_inc  = (bytes_q == '1) ? bytes_q : bytes_q + CountW'(1);
  assign hit        = !reported_q && (bytes_inc >= CountW'(cfg_i.len)) && step_i.match;
  assign report_now = hit && !(matches_q < cfg_i.skip);

  always_comb begin
    bytes_d    = bytes_q;
    matches_d  = matches_q;
    reported_d = reported_q;
    found_d    = found_q;
    offset_d   = offset_q;
    emit       = 1'b0;
    if (step_i.accept) begin
      bytes_d = bytes_inc;
      if (hit && !report_now) begin
        matches_d = matches_q + CountW'(1);
      end
      if (report_now) begin
        reported_d = 1'b1;
        emit       = 1'b1;
        found_d    = 1'b1;
        offset_d   = bytes_inc - CountW'(cfg_i.len);
      end
      if (step_i.last) begin
        if (!report_now && !reported_q) begin
          emit     = 1'b1;
          found_d  = 1'b0;
          offset_d = '0;
        end
        bytes_d    = '0;
        matches_d  = '0;
        reported_d = 1'b0;
      end
    end
    valid_d = emit || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q    <= '0;
      matches_q  <= '0;
      reported_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      bytes_q    <= bytes_d;
      matches_q  <= matches_d;
      reported_q <= reported_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_valid_o = valid_q;
  assign found_o     = found_q;
  assign offset_o    = offset_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.accept && step_i.last) |=> (bytes_q == '0 && matches_q == '0 && !reported_q))
    else $error("region state not cleared after last byte");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !found_q) |-> (offset_q == '0))
    else $error("not-found result carries a nonzero offset");

  a_reported_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> (bytes_q != '0))
    else $error("match reported with no bytes counted");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.accept && valid_q) |-> out_ready_i)
    else $error("request accepted while result slot is blocked");

endmodule

// File: hw/rtl/wildcard_byte_pattern_scanner.sv
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid / tready   tdata[7:0] data_byte, tlast end_of_region
// m_axis    out  tvalid / tready   tuser[0] found, tdata[31:0] match_offset
// cfg       in   cfg_we_i          cfg_idx_i register index, cfg_wdata_i value
//
// One byte request is taken every cycle while the result slot is free; its
// result, if any, appears in the output register on the next cycle. The
// per-byte path is the window shift, the masked compare of up to
// MAX_PATTERN_LEN positions and the 32-bit counter update. Reset clears
// the window, the counters and the result slot. A stalled result holds in
// the output register; a new byte is still taken in the cycle it drains.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN_LEN = wbps_pkg::MaxPatternLen
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave side byte stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                          s_axis_tlast_i,   // end_of_region
  // Master side results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [31:0]                   m_axis_tdata_o,   // [31:0] match_offset
  output logic [0:0]                    m_axis_tuser_o,   // [0] found
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import wbps_pkg::*;

  cfg_t  cfg;
  step_t step;
  logic  out_free;
  logic  match;
  logic  found;

  // Take a byte whenever the result slot is empty or draining this cycle
  assign s_axis_tready_o = out_free;

  wbps_cfg_regs #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Shift window and masked compare against the new byte
  wbps_window #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (step.accept),
    .last_i   (s_axis_tlast_i),
    .byte_i   (s_axis_tdata_i),
    .cfg_i    (cfg),
    .match_o  (match)
  );

  assign step.accept = s_axis_tvalid_i && out_free;
  assign step.last   = s_axis_tlast_i;
  assign step.match  = match;

  // Counters, skip handling and the output register
  wbps_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cfg_i       (cfg),
    .out_ready_i (m_axis_tready_i),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .found_o     (found),
    .offset_o    (m_axis_tdata_o)
  );

  assign m_axis_tuser_o = found;

endmodule

// File: sim/testbench.sv
module testbench;
  import wbps_pkg::*;

  // Watchdog limit: cycles in a row with no request moving on either side.
  // The longest legal quiet stretch is the forced receiver hold-off plus a
  // few idle bursts and register writes, so this leaves a wide margin.
  localparam int unsigned QuietLimit = 2000;
  // Length of the one long receiver hold-off that backs up the block
  localparam int unsigned HoldCycles = 120;
  // Bytes sent in each random phase
  localparam int unsigned PhaseBytes = 113;
  localparam int unsigned NumPhases  = 10;
  // Directed pattern: byte 0 is 8'h00, byte 1 is 8'hFF, the rest mixed
  localparam logic [127:0] DirPattern = 128'hFF00_8001_7FFE_C33C_A55A_0F0F_F0F0_FF00;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } scan_hit_t;

  // Tracks the scan state of the current region and holds the results that
  // the block still owes, oldest first.
  class scan_tracker;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  len_reg;
    logic [31:0] skip;
    logic [7:0]  window [16];
    logic [31:0] seen;
    logic [31:0] passed;
    bit          reported;
    scan_hit_t   results_due [$];
    int unsigned errors;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      care    = '0;
      len_reg = 5'd1;
      skip    = '0;
      errors  = 0;
      clear_region();
    endfunction

    function void clear_region();
      window   = '{default: 8'h00};
      seen     = '0;
      passed   = '0;
      reported = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] value);
      case (idx)
        RegPatternLow:  pat_lo  = value;
        RegPatternHigh: pat_hi  = value;
        RegCareMask:    care    = value[15:0];
        RegPatternLen:  len_reg = value[4:0];
        RegSkipCount:   skip    = value[31:0];
        default: ;
      endcase
    endfunction

    // Advance the region by one accepted byte request and queue its result
    function void take_byte(logic [7:0] b, logic last);
      logic [127:0] pat;
      int unsigned  n;
      bit           hit;
      scan_hit_t    r;
      pat = {pat_hi, pat_lo};
      // Zero length acts as one, oversized length is clamped
      if (len_reg == 0) n = 1;
      else if (len_reg > MaxPatternLen) n = MaxPatternLen;
      else n = len_reg;
      for (int i = 15; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (seen != 32'hFFFF_FFFF) seen++;
      if (!reported && seen >= n) begin
        hit = 1'b1;
        // Pattern byte j sits j bytes after the oldest byte in the window
        for (int j = 0; j < n; j++) begin
          if (care[j] && window[n-1-j] != pat[8*j +: 8]) hit = 1'b0;
        end
        if (hit) begin
          if (passed < skip) begin
            passed++;
          end else begin
            reported = 1'b1;
            r.found  = 1'b1;
            r.offset = 32'(seen - n);
            results_due = {results_due, r};
          end
        end
      end
      if (last) begin
        if (!reported) begin
          r.found  = 1'b0;
          r.offset = '0;
          results_due = {results_due, r};
        end
        clear_region();
      end
    endfunction

    function void check_result(logic found, logic [31:0] offset);
      scan_hit_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing due: found %0d, match_offset %0d", found, offset);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (offset !== want.offset) begin
        $error("match_offset: expected %0d, actual %0d", want.offset, offset);
        errors++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [7:0]  s_data    = '0;
  logic        s_last    = 1'b0;
  logic        m_ready   = 1'b1;
  logic        cfg_we    = 1'b0;
  cfg_reg_e    cfg_idx   = RegPatternLow;
  logic [63:0] cfg_wdata = '0;

  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_data;
  logic [0:0]  m_user;

  // Handshake flags between the sender and the receiver process
  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  // Setup of the phase being sent, used to shape the byte stream
  logic [127:0] cur_pat;
  logic [15:0]  cur_care;
  int unsigned  cur_n;

  int unsigned  quiet = 0;
  scan_tracker  tracker;

  wildcard_byte_pattern_scanner uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check every result request taken at a rising edge; the block updates on
  // nonblocking assignments, so the values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) tracker.check_result(m_user[0], m_data);
  end

  // Watchdog: count cycles with no request moving, give up at the limit
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("** wildcard_byte_pattern_scanner: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none once
  // the run goes calm.
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        m_ready  = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n       = $urandom_range(1, 7);
        m_ready = 1'b0;
        repeat (n) @(negedge clk);
        m_ready = 1'b1;
      end else begin
        m_ready = 1'b1;
      end
    end
  end

  // Write one register; enter and leave on a falling edge with no byte offered
  task automatic cfg_write(cfg_reg_e idx, logic [63:0] value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.write_reg(idx, value);
  endtask

  // Hold until every owed result has drained, then let the pipeline empty
  task automatic settle();
    while (tracker.results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Offer one byte request; enter and leave on a falling edge. Valid stays
  // high across back-to-back bytes and drops only for an idle burst.
  task automatic push_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap     = $urandom_range(1, 7);
      s_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid = 1'b1;
    s_data  = b;
    s_last  = last;
    do @(posedge clk); while (!s_ready);
    tracker.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic load_setup(logic [127:0] pat, logic [15:0] care_v, logic [4:0] len_v,
                            logic [31:0] skip_v);
    cfg_write(RegPatternLow, pat[63:0]);
    cfg_write(RegPatternHigh, pat[127:64]);
    cfg_write(RegCareMask, {48'd0, care_v});
    cfg_write(RegPatternLen, {59'd0, len_v});
    cfg_write(RegSkipCount, {32'd0, skip_v});
    cur_pat  = pat;
    cur_care = care_v;
    cur_n    = (len_v == 0) ? 1 : ((len_v > MaxPatternLen) ? MaxPatternLen : len_v);
  endtask

  // One setup, then a stream of regions. Most regions are built around the
  // pattern so that matches, skipped matches and late matches all occur;
  // the rest are noise and regions shorter than the pattern. The budget may
  // cut the last region, which leaves it open across the next setup.
  task automatic run_phase(int unsigned idx, int unsigned budget);
    logic [7:0]   region_q [$];
    logic [127:0] pat;
    logic [15:0]  care_v;
    logic [4:0]   len_v;
    logic [31:0]  skip_v;
    logic [7:0]   pick;
    int unsigned  sent;
    int unsigned  len_r;
    int unsigned  kind;
    int unsigned  start;
    int unsigned  j;
    bit           close;
    pat    = {$urandom, $urandom, $urandom, $urandom};
    care_v = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom & $urandom);
    len_v  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
    skip_v = $urandom_range(0, 3);
    case (idx)
      0: begin pat = '0; care_v = 16'hFFFF; len_v = 5'd0; skip_v = '0; end
      1: begin pat = '1; care_v = 16'hFFFF; len_v = 5'd16; skip_v = '0; end
      2: begin len_v = 5'd31; skip_v = 32'd2; end
      // Everything matches but nothing is ever reported
      3: begin care_v = '0; len_v = 5'd5; skip_v = 32'hFFFF_FFFF; end
      4: len_v = 5'd1;
      5: begin len_v = 5'd17; skip_v = '0; end
      default: ;
    endcase
    settle();
    load_setup(pat, care_v, len_v, skip_v);
    if (idx == 4) hold_req = 1'b1;
    if (idx == NumPhases - 1) calm = 1'b1;
    sent = 0;
    while (sent < budget) begin
      region_q.delete();
      kind = $urandom_range(0, 9);
      if (kind < 2 || (kind < 3 && cur_n == 1)) begin
        len_r = $urandom_range(1, 24);
        repeat (len_r) begin
          pick     = 8'($urandom);
          region_q = {region_q, pick};
        end
      end else if (kind < 3) begin
        // Short region: a true prefix of the pattern never fills the window
        len_r = $urandom_range(1, cur_n - 1);
        for (int i = 0; i < len_r; i++) begin
          pick     = cur_pat[8*i +: 8];
          region_q = {region_q, pick};
        end
      end else begin
        len_r = cur_n + $urandom_range(0, 24);
        for (int i = 0; i < len_r; i++) begin
          j        = $urandom_range(0, cur_n - 1);
          pick     = ($urandom_range(0, 1) == 0) ? 8'($urandom) : cur_pat[8*j +: 8];
          region_q = {region_q, pick};
        end
        // Plant copies; wildcard positions keep their random background
        repeat ($urandom_range(1, 4)) begin
          start = $urandom_range(0, len_r - cur_n);
          for (int k = 0; k < cur_n; k++) begin
            if (cur_care[k]) region_q[start + k] = cur_pat[8*k +: 8];
          end
        end
      end
      close = 1'b1;
      if (len_r > budget - sent) begin
        len_r = budget - sent;
        close = 1'b0;
      end
      for (int i = 0; i < len_r; i++) push_byte(region_q[i], close && (i == len_r - 1));
      sent += len_r;
    end
    s_valid = 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Zero length acts as one; with every byte a wildcard the single byte
    // matches on the last byte of the region, so only the found result comes.
    cfg_write(RegPatternLen, 64'd0);
    push_byte(8'hFF, 1'b1);
    s_valid = 1'b0;
    settle();

    // Oversized length clamps to sixteen. A three-byte region is too short;
    // then the full pattern matches on its last byte at offset zero.
    cfg_write(RegPatternLow, DirPattern[63:0]);
    cfg_write(RegPatternHigh, DirPattern[127:64]);
    cfg_write(RegCareMask, 64'hFFFF);
    cfg_write(RegPatternLen, 64'd17);
    for (int i = 0; i < 3; i++) push_byte(DirPattern[8*i +: 8], i == 2);
    for (int i = 0; i < 16; i++) push_byte(DirPattern[8*i +: 8], i == 15);
    s_valid = 1'b0;
    settle();

    // Two-byte pattern with a wildcard second byte and one match skipped:
    // the match at offset zero is passed over, the one at offset two reported.
    cfg_write(RegPatternLen, 64'd2);
    cfg_write(RegCareMask, 64'h0001);
    cfg_write(RegSkipCount, 64'd1);
    push_byte(DirPattern[7:0], 1'b0);
    push_byte(~DirPattern[7:0], 1'b0);
    push_byte(DirPattern[7:0], 1'b0);
    push_byte(8'h5A, 1'b1);
    s_valid = 1'b0;

    for (int p = 0; p < NumPhases; p++) run_phase(p, PhaseBytes);

    // Drain what is owed; the watchdog catches a result that never comes
    while (tracker.results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.results_due.size() == 0) begin
      $display("** wildcard_byte_pattern_scanner: PASSED **");
    end else begin
      $display("** wildcard_byte_pattern_scanner: FAILED **");
    end
    $finish;
  end

endmodule
